[design/erpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erpd_pkg: shared types and constants of the ECG R-peak detector
// Field widths, defaults, the divide-by-ten reciprocal and the sequencer types.
// ----------------------------------------------------------------------------
package erpd_pkg;

  // field widths
  localparam int SAMPLE_W = 24;
  localparam int TIME_W   = 32;
  localparam int BASE_W   = 25;
  localparam int HEIGHT_W = 26;

  // stream widths, tdata in whole bytes
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 1;

  // default geometry
  localparam int DEPTH_DEF  = 128;
  localparam int WINDOW_DEF = 49;

  // baseline span relative to the centre
  localparam int BASE_FIRST = 10;
  localparam int BASE_LAST  = 20;
  localparam int BASE_TERMS = BASE_LAST - BASE_FIRST + 1;

  // divide by ten: q = (n * DIV10_MULT) >> DIV10_SHIFT, exact for n < 2**26
  localparam int MAG_W       = 24;
  localparam int QUOT_W      = 21;
  localparam int DIV10_SHIFT = 27;
  localparam logic [MAG_W-1:0] DIV10_MULT = 24'd13421773;

  // sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SUM,
    ST_BASE,
    ST_EMIT
  } erpd_state_t;

  typedef struct packed {
    logic shift_en;
    logic sum_en;
    logic base_en;
    logic out_load;
  } erpd_ctrl_t;

endpackage : erpd_pkg
`default_nettype wire

[design/erpd_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erpd_cell: one delay line position
// Holds a sample and its timestamp, passes them on at each shift and compares
// its own sample against the broadcast centre sample.
// ----------------------------------------------------------------------------
module erpd_cell (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                shift_en,
  input  wire logic signed [erpd_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic        [erpd_pkg::TIME_W-1:0]   time_in,
  input  wire logic signed [erpd_pkg::SAMPLE_W-1:0] centre,
  output logic signed      [erpd_pkg::SAMPLE_W-1:0] sample_out,
  output logic             [erpd_pkg::TIME_W-1:0]   time_out,
  output logic                                      gt_out,
  output logic                                      ge_out
);
  import erpd_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic        [TIME_W-1:0]   time_r;
  logic                       gt_r;
  logic                       ge_r;

  // line contents, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      time_r   <= '0;
    end else if (shift_en) begin
      sample_r <= sample_in;
      time_r   <= time_in;
    end
  end

  // compare against the centre every cycle
  always_ff @(posedge clk) begin
    gt_r <= (sample_r > centre);
    ge_r <= (sample_r >= centre);
  end

  assign sample_out = sample_r;
  assign time_out   = time_r;
  assign gt_out     = gt_r;
  assign ge_out     = ge_r;

endmodule : erpd_cell
`default_nettype wire

[design/erpd_div10.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erpd_div10: signed divide by ten, truncating toward zero
// Reciprocal multiply on the magnitude, sign restored, result registered.
// ----------------------------------------------------------------------------
module erpd_div10 (
  input  wire logic                                clk,
  input  wire logic signed [erpd_pkg::SAMPLE_W-1:0] din,
  output logic signed      [erpd_pkg::SAMPLE_W-1:0] dout
);
  import erpd_pkg::*;

  logic                       neg;
  logic [MAG_W-1:0]           mag;
  logic [2*MAG_W-1:0]         prod;
  logic [QUOT_W-1:0]          quot;
  logic signed [SAMPLE_W-1:0] q_ext;
  logic signed [SAMPLE_W-1:0] q_r;

  // magnitude, reciprocal multiply, sign restore
  always_comb begin
    neg   = din[SAMPLE_W-1];
    mag   = neg ? (~din + 1'b1) : din;
    prod  = mag * DIV10_MULT;
    quot  = prod[DIV10_SHIFT +: QUOT_W];
    q_ext = {{(SAMPLE_W-QUOT_W){1'b0}}, quot};
    if (neg) begin
      q_ext = -q_ext;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_ext;
  end

  assign dout = q_r;

endmodule : erpd_div10
`default_nettype wire

[design/erpd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erpd_ctrl: per-sample sequencer
// Takes one transaction, steps it through compare, sum and baseline stages
// and loads the output register once it is free.
// ----------------------------------------------------------------------------
module erpd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 out_free,
  output logic                      in_ready,
  output erpd_pkg::erpd_ctrl_t      ctrl
);
  import erpd_pkg::*;

  erpd_state_t state_r;
  erpd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_BASE;
      ST_BASE: state_nxt = ST_EMIT;
      ST_EMIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    ctrl     = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctrl.shift_en = in_valid;
      end
      ST_EVAL: ;
      ST_SUM:  ctrl.sum_en  = 1'b1;
      ST_BASE: ctrl.base_en = 1'b1;
      ST_EMIT: ctrl.out_load = out_free;
      default: ;
    endcase
  end

endmodule : erpd_ctrl
`default_nettype wire

[design/ecg_r_peak_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecg_r_peak_detector: sliding-window local maximum R-peak detector
// A chain of cells holds the sample and timestamp history; the centre sample
// is checked against its window and a baseline of older samples is formed.
// ----------------------------------------------------------------------------
//  channel | direction | tdata fields (low bit up)                 | tuser
//  in_     | slave     | sample[23:0], timestamp[55:24]            | -
//  out_    | master    | peak_time[31:0], baseline[56:32],         | is_peak[0]
//          |           | peak_height[82:57], zero pad [87:83]      |
//
// Each sample passes from acceptance to a loaded result through one shift of
// the cell chain, one registered compare in every cell (with the divide by
// ten), two adder stages for the baseline and a combinational height.
// A new sample is accepted in the cycle after the result register is loaded,
// even while that result still waits for out_tready; a stalled output holds
// the sequencer only when a second result is ready. Reset clears the whole
// line to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ecg_r_peak_detector #(
  parameter int DEPTH  = erpd_pkg::DEPTH_DEF,
  parameter int WINDOW = erpd_pkg::WINDOW_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [erpd_pkg::IN_DATA_W-1:0]     in_tdata,   // sample, timestamp
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [erpd_pkg::OUT_DATA_W-1:0]         out_tdata,  // peak_time, baseline, peak_height
  output logic [erpd_pkg::OUT_USER_W-1:0]         out_tuser   // is_peak
);
  import erpd_pkg::*;

  localparam int HALF = DEPTH / 2;

  erpd_ctrl_t ctrl;
  logic       out_free;

  logic signed [SAMPLE_W-1:0] line_s [DEPTH];
  logic        [TIME_W-1:0]   line_t [DEPTH];
  logic [DEPTH-1:0]           gt_v;
  logic [DEPTH-1:0]           ge_v;
  logic [DEPTH-1:0]           bad_v;
  logic signed [SAMPLE_W-1:0] centre;
  logic signed [SAMPLE_W-1:0] quot [BASE_TERMS];

  logic                       peak_r;
  logic signed [BASE_W-1:0]   part0_r;
  logic signed [BASE_W-1:0]   part1_r;
  logic signed [BASE_W-1:0]   part2_r;
  logic signed [BASE_W-1:0]   base_r;
  logic signed [HEIGHT_W-1:0] height;

  logic                       out_valid_r;
  logic                       is_peak_r;
  logic [TIME_W-1:0]          peak_time_r;
  logic signed [BASE_W-1:0]   baseline_r;
  logic signed [HEIGHT_W-1:0] peak_height_r;

  assign centre   = line_s[HALF];
  assign out_free = !out_valid_r || out_tready;

  // sequencer
  erpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctrl     (ctrl)
  );

  // cell chain, position 0 takes the new transaction
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] s_in;
    logic        [TIME_W-1:0]   t_in;
    if (i == 0) begin : g_head
      assign s_in = in_tdata[SAMPLE_W-1:0];
      assign t_in = in_tdata[SAMPLE_W +: TIME_W];
    end else begin : g_body
      assign s_in = line_s[i-1];
      assign t_in = line_t[i-1];
    end
    erpd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (ctrl.shift_en),
      .sample_in  (s_in),
      .time_in    (t_in),
      .centre     (centre),
      .sample_out (line_s[i]),
      .time_out   (line_t[i]),
      .gt_out     (gt_v[i]),
      .ge_out     (ge_v[i])
    );
    // newer positions may not exceed the centre, older ones may not reach it
    if ((i >= HALF - WINDOW) && (i <= HALF + WINDOW - 1) && (i < HALF)) begin : g_new
      assign bad_v[i] = gt_v[i];
    end else if ((i <= HALF + WINDOW - 1) && (i > HALF)) begin : g_old
      assign bad_v[i] = ge_v[i];
    end else begin : g_out
      assign bad_v[i] = 1'b0;
    end
  end

  // divide each baseline sample by ten
  for (genvar k = 0; k < BASE_TERMS; k++) begin : g_div
    erpd_div10 u_div (
      .clk  (clk),
      .din  (line_s[HALF + BASE_FIRST + k]),
      .dout (quot[k])
    );
  end

  // peak decision and partial baseline sums
  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      peak_r  <= (centre != '0) && !(|bad_v);
      part0_r <= BASE_W'(quot[0]) + BASE_W'(quot[1]) + BASE_W'(quot[2]) + BASE_W'(quot[3]);
      part1_r <= BASE_W'(quot[4]) + BASE_W'(quot[5]) + BASE_W'(quot[6]) + BASE_W'(quot[7]);
      part2_r <= BASE_W'(quot[8]) + BASE_W'(quot[9]) + BASE_W'(quot[10]);
    end
  end

  // total baseline
  always_ff @(posedge clk) begin
    if (ctrl.base_en) begin
      base_r <= part0_r + part1_r + part2_r;
    end
  end

  assign height = HEIGHT_W'(centre) - HEIGHT_W'(base_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      is_peak_r     <= peak_r;
      peak_time_r   <= peak_r ? line_t[HALF] : '0;
      baseline_r    <= peak_r ? base_r : '0;
      peak_height_r <= peak_r ? height : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = is_peak_r;
  assign out_tdata  = {{(OUT_DATA_W-TIME_W-BASE_W-HEIGHT_W){1'b0}},
                       peak_height_r, baseline_r, peak_time_r};

`ifndef NO_ASSERTIONS
  // one sample in flight: no acceptance right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction accepted while one is in flight");

  // a result without a peak carries all-zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("non-peak result with nonzero fields");

  // a reported peak has a nonzero centre sample
  a_peak_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      ((HEIGHT_W'(peak_height_r) + HEIGHT_W'(baseline_r)) != '0))
    else $error("peak reported on a zero centre sample");
`endif

endmodule : ecg_r_peak_detector
`default_nettype wire
